/* sv/bspg_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bspg_pkg
// types and constants shared by the short-press gesture detector
// ---------------------------------------------------------------------------
package bspg_pkg;

	localparam int CFG_W = 16;
	localparam int IDX_W = 2;
	localparam int CNT_W = 4;
	localparam int IN_TIME_W = 32;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_SHORT_LIMIT = 2'd0;
	localparam logic [IDX_W-1:0] REG_GAP_MIN = 2'd1;
	localparam logic [IDX_W-1:0] REG_GAP_MAX = 2'd2;

	localparam logic [CFG_W-1:0] RST_SHORT_LIMIT = 16'd500;
	localparam logic [CFG_W-1:0] RST_GAP_MIN = 16'd500;
	localparam logic [CFG_W-1:0] RST_GAP_MAX = 16'd4000;

	localparam logic [CNT_W-1:0] TRAIN_MAX = 4'd10;
	localparam logic [CNT_W-1:0] SETUP_NOW = 4'd2;
	localparam logic [CNT_W-1:0] SETUP_PREV = 4'd3;

	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic [CFG_W-1:0] short_limit;
		logic [CFG_W-1:0] gap_min;
		logic [CFG_W-1:0] gap_max;
	} cfg_t;

	typedef struct packed {
		logic level_changed;
		logic setup_gesture;
	} result_t;

endpackage

/* sv/bspg_in_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bspg_in_if
// sample channel: timestamp and button level
// ---------------------------------------------------------------------------
interface bspg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] time_ms;
	logic        level;

	modport source (output valid, output time_ms, output level, input ready);
	modport sink (input valid, input time_ms, input level, output ready);
endinterface

/* sv/bspg_out_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bspg_out_if
// result channel: level change and setup gesture flags
// ---------------------------------------------------------------------------
interface bspg_out_if;
	logic valid;
	logic ready;
	logic level_changed;
	logic setup_gesture;

	modport source (output valid, output level_changed, output setup_gesture, input ready);
	modport sink (input valid, input level_changed, input setup_gesture, output ready);
endinterface

/* sv/button_short_press_gesture.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// button_short_press_gesture
// short-press train counter with three-then-two setup gesture detection
// ---------------------------------------------------------------------------
// channel   dir  handshake      payload
// sample    in   valid/ready    time_ms[31:0], level
// result    out  valid/ready    level_changed, setup_gesture
// wr_*      in   wr_en          wr_index[1:0], wr_data[15:0]
//
// one transaction per cycle sustained while the result is taken; a sample waits in the
// input register until the train state updates, and its result shows in the cycle after
// reset returns levels to released, counts and times to zero, limits to defaults
// a stalled result holds the result register and a full input register;
// a sample is taken only while the input register is empty or moving on
// ---------------------------------------------------------------------------
module button_short_press_gesture
	import bspg_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	bspg_in_if.sink          sample,
	bspg_out_if.source       result,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	cfg_t                 cfg;
	result_t              res;
	logic                 valid_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 level_s1;
	logic                 valid_s2;
	result_t              res_s2;
	logic                 advance;
	logic                 fire;

	bspg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	bspg_step #(
		.TIME_BITS (TIME_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.now    (time_s1),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign advance = !valid_s2 || result.ready;
	assign fire = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			time_s1 <= TIME_BITS'(sample.time_ms);
			level_s1 <= sample.level;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign result.valid = valid_s2;
	assign result.level_changed = res_s2.level_changed;
	assign result.setup_gesture = res_s2.setup_gesture;

endmodule

/* sv/bspg_cfg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bspg_cfg
// configuration registers written through a plain write port
// ---------------------------------------------------------------------------
module bspg_cfg
	import bspg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_limit <= RST_SHORT_LIMIT;
			cfg_q.gap_min <= RST_GAP_MIN;
			cfg_q.gap_max <= RST_GAP_MAX;
		end else if (wr_en) begin
			case (wr_index)
				REG_SHORT_LIMIT: cfg_q.short_limit <= wr_data;
				REG_GAP_MIN: cfg_q.gap_min <= wr_data;
				REG_GAP_MAX: cfg_q.gap_max <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/bspg_step.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bspg_step
// press train state and per-sample update, one sample per cycle on fire
// ---------------------------------------------------------------------------
module bspg_step
	import bspg_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [TIME_BITS-1:0] now,
	input  logic                 level,
	input  cfg_t                 cfg,
	output result_t              res
);

	localparam int CW = (TIME_BITS > CFG_W + 1) ? TIME_BITS : CFG_W + 1;

	logic                 level_q;
	logic [TIME_BITS-1:0] last_change_q;
	count_t               count_q;
	count_t               prev_count_q;
	logic [TIME_BITS-1:0] train_time_q;
	logic [TIME_BITS-1:0] prev_time_q;

	logic                 changed;
	logic                 release_edge;
	logic [TIME_BITS-1:0] elapsed;
	logic                 is_short;
	count_t               count_a;
	count_t               prev_count_a;
	logic [TIME_BITS-1:0] train_time_a;
	logic [CW-1:0]        close_limit;
	logic                 close;
	logic [TIME_BITS-1:0] gap;
	logic                 gap_ok;
	logic                 setup;

	always_comb begin
		changed = (level != level_q);
		release_edge = changed && level;
		elapsed = now - last_change_q;
		is_short = CW'(elapsed) < CW'(cfg.short_limit);

		count_a = count_q;
		prev_count_a = prev_count_q;
		train_time_a = train_time_q;
		if (release_edge) begin
			if (is_short) begin
				if (count_q < TRAIN_MAX) begin
					count_a = count_q + count_t'(1);
				end
				train_time_a = now;
			end else begin
				count_a = '0;
				prev_count_a = '0;
			end
		end

		// elapsed time is not cleared on a change, so a close excludes a change
		close_limit = CW'({cfg.short_limit, 1'b0});
		close = level && !changed && (count_a != '0) && (CW'(elapsed) > close_limit);

		gap = train_time_a - prev_time_q;
		gap_ok = (CW'(gap) >= CW'(cfg.gap_min)) && (CW'(gap) <= CW'(cfg.gap_max));
		setup = close && (count_a == SETUP_NOW) && (prev_count_a == SETUP_PREV) && gap_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b1;
			last_change_q <= '0;
			count_q <= '0;
			prev_count_q <= '0;
			train_time_q <= '0;
			prev_time_q <= '0;
		end else if (fire) begin
			if (changed) begin
				level_q <= level;
				last_change_q <= now;
			end
			train_time_q <= train_time_a;
			if (close) begin
				count_q <= '0;
				prev_count_q <= count_a;
				prev_time_q <= train_time_a;
			end else begin
				count_q <= count_a;
				prev_count_q <= prev_count_a;
			end
		end
	end

	assign res.level_changed = changed;
	assign res.setup_gesture = setup;

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= TRAIN_MAX) && (prev_count_q <= TRAIN_MAX))
		else $error("train count above saturation");

	a_setup_not_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		setup |-> !changed)
		else $error("setup flagged on a level change");

	a_setup_closes_train: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && setup) |=> (count_q == '0) && (prev_count_q == SETUP_NOW))
		else $error("setup did not close the train");

	a_change_stores_level: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && changed) |=> (level_q == $past(level)) && (last_change_q == $past(now)))
		else $error("level change not recorded");

endmodule
